// ===== rtl/core/slpg_pkg.sv =====
`default_nettype none

package slpg_pkg;

  // Default flash countdown, in millisecond ticks
  localparam int unsigned FLASH_LENGTH_DEF = 200;

  // Field and bus widths
  localparam int unsigned RgbW      = 24;
  localparam int unsigned ChanW     = 8;
  localparam int unsigned MaskW     = 6;
  localparam int unsigned IdxW      = 3;
  localparam int unsigned ShownW    = 3;
  localparam int unsigned PhaseW    = 12;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned InDataW   = 8;
  localparam int unsigned InUserW   = 2;
  localparam int unsigned OutDataW  = 40;

  // Output tdata layout, lowest bit first
  localparam int unsigned OutRedLsb   = 0;
  localparam int unsigned OutGreenLsb = 8;
  localparam int unsigned OutBlueLsb  = 16;
  localparam int unsigned OutShownLsb = 24;
  localparam int unsigned OutMaskLsb  = 27;
  localparam int unsigned OutUsedW    = 33;

  // Timing constants in milliseconds
  localparam logic [PhaseW-1:0] PhaseLast    = 12'd3999;
  localparam logic [PhaseW-1:0] OfflineBlink = 12'd100;
  localparam logic [PhaseW-1:0] BreathePer   = 12'd2000;
  localparam logic [PhaseW-1:0] BreatheHalf  = 12'd1000;
  localparam logic [PhaseW-1:0] ErrOn0End    = 12'd500;
  localparam logic [PhaseW-1:0] ErrOn1Beg    = 12'd1000;
  localparam logic [PhaseW-1:0] ErrOn1End    = 12'd1500;
  localparam logic [PhaseW-1:0] ErrOn2Beg    = 12'd2000;
  localparam logic [PhaseW-1:0] ErrOn2End    = 12'd2500;
  localparam logic [PhaseW-1:0] ErrOn3Beg    = 12'd3000;
  localparam logic [PhaseW-1:0] ErrOn3End    = 12'd3500;

  // Breathe ramp: x*255/1000 == (x * BreatheMul) >> BreatheShift for x in 0..1000
  localparam int unsigned BreatheXW     = 11;
  localparam int unsigned BreatheShift  = 18;
  localparam int unsigned BreatheProdW  = 27;
  localparam logic [BreatheProdW-1:0] BreatheMul = 27'd66847;

  // Color register reset values
  localparam logic [RgbW-1:0] RstRed    = 24'hFF0000;
  localparam logic [RgbW-1:0] RstGreen  = 24'h00FF00;
  localparam logic [RgbW-1:0] RstYellow = 24'hFFFF00;
  localparam logic [RgbW-1:0] RstBlue   = 24'h0000FF;
  localparam logic [RgbW-1:0] RstOrange = 24'hFF8000;
  localparam logic [RgbW-1:0] RstWhite  = 24'hFFFFFF;

  // Input beat kinds
  typedef enum logic [InUserW-1:0] {
    KIND_TICK  = 2'd0,
    KIND_SET   = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_FLASH = 2'd3
  } kind_t;

  // Status bit positions in the mask
  localparam logic [IdxW-1:0] ST_BOOT      = 3'd0;
  localparam logic [IdxW-1:0] ST_DISARMED  = 3'd1;
  localparam logic [IdxW-1:0] ST_ARMED     = 3'd2;
  localparam logic [IdxW-1:0] ST_OFFLINE   = 3'd3;
  localparam logic [IdxW-1:0] ST_DETECTION = 3'd4;
  localparam logic [IdxW-1:0] ST_ERROR     = 3'd5;

  // Reported status codes
  typedef enum logic [ShownW-1:0] {
    SHOWN_OFF       = 3'd0,
    SHOWN_BOOT      = 3'd1,
    SHOWN_DISARMED  = 3'd2,
    SHOWN_ARMED     = 3'd3,
    SHOWN_OFFLINE   = 3'd4,
    SHOWN_DETECTION = 3'd5,
    SHOWN_ERROR     = 3'd6
  } shown_t;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_RED    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_GREEN  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_YELLOW = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_BLUE   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ORANGE = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_WHITE  = 3'd5;

endpackage

`default_nettype wire

// ===== rtl/core/status_led_pattern_generator.sv =====
`default_nettype none

// Status LED pattern engine. Each input beat is a 1 ms tick, a set or clear
// of one status bit, or a detection flash trigger; every beat yields exactly
// one output beat carrying the RGB color to show, the winning status and the
// active-status mask after that beat. The block takes one beat per clock
// unless a stalled result holds it off. A beat updates the state registers
// (mask, 0..3999 ms phase, flash countdown) at acceptance, and the color
// logic fed by those registers loads the output register once it is free.
// Color registers are written through the cfg port, which is always ready;
// write them only while no beat is in flight.
module status_led_pattern_generator
  import slpg_pkg::*;
#(
  parameter int unsigned FLASH_LENGTH = FLASH_LENGTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // in_tdata: [2:0] status_index, [7:3] zero
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [InDataW-1:0]  in_tdata,
  // in_tuser: [1:0] kind
  input  wire logic [InUserW-1:0]  in_tuser,
  // out_tdata: [7:0] red, [15:8] green, [23:16] blue, [26:24] shown_status,
  //            [32:27] active_mask, [39:33] zero
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [OutDataW-1:0]      out_tdata,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [RgbW-1:0]     cfg_data
);

  localparam int unsigned FlashW = $clog2(FLASH_LENGTH + 1);
  localparam logic [FlashW-1:0] FlashLoad = FlashW'(FLASH_LENGTH);

  // Color registers
  logic [RgbW-1:0] red_r, green_r, yellow_r, blue_r, orange_r, white_r;

  // State registers
  logic [MaskW-1:0]  mask_r,  mask_nxt;
  logic [PhaseW-1:0] phase_r, phase_nxt;
  logic [FlashW-1:0] flash_r, flash_nxt;
  logic              pend_r,  pend_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [OutDataW-1:0] out_data_r,  out_data_nxt;

  logic          in_fire, out_take;
  kind_t         kind;
  logic [IdxW-1:0] idx;
  logic [MaskW-1:0] idx_bit;

  assign cfg_ready = 1'b1;
  assign out_take  = !out_valid_r || out_tready;
  assign in_tready = !pend_r || out_take;
  assign in_fire   = in_tvalid && in_tready;
  assign kind      = kind_t'(in_tuser);
  assign idx       = in_tdata[IdxW-1:0];
  assign idx_bit   = (idx <= ST_ERROR) ? (MaskW'(1) << idx) : '0;

  // State update for an accepted beat
  always_comb begin
    mask_nxt  = mask_r;
    phase_nxt = phase_r;
    flash_nxt = flash_r;
    if (in_fire) begin
      case (kind)
        KIND_TICK: begin
          phase_nxt = (phase_r == PhaseLast) ? '0 : phase_r + PhaseW'(1);
          flash_nxt = (flash_r != '0) ? flash_r - FlashW'(1) : flash_r;
        end
        KIND_SET:   mask_nxt  = mask_r | idx_bit;
        KIND_CLEAR: mask_nxt  = mask_r & ~idx_bit;
        KIND_FLASH: flash_nxt = FlashLoad;
        default:    mask_nxt  = mask_r;
      endcase
    end
  end

  // A pending state is one whose result has not yet entered the output register
  always_comb begin
    pend_nxt = pend_r;
    if (in_fire) begin
      pend_nxt = 1'b1;
    end else if (out_take) begin
      pend_nxt = 1'b0;
    end
  end

  // Pattern timing from the phase counter
  logic                    err_on;
  logic [BreatheXW-1:0]    br_p, br_x;
  logic [BreatheProdW-1:0] br_prod;
  logic [ChanW-1:0]        breathe;
  logic [RgbW-1:0]         base_rgb, rgb;
  shown_t                  shown;

  assign err_on = (phase_r < ErrOn0End) ||
                  (phase_r >= ErrOn1Beg && phase_r < ErrOn1End) ||
                  (phase_r >= ErrOn2Beg && phase_r < ErrOn2End) ||
                  (phase_r >= ErrOn3Beg && phase_r < ErrOn3End);

  // Triangle over 2000 ms, scaled to 0..255
  assign br_p    = (phase_r >= BreathePer) ? BreatheXW'(phase_r - BreathePer)
                                           : BreatheXW'(phase_r);
  assign br_x    = (br_p < BreatheXW'(BreatheHalf)) ? br_p
                                                    : BreatheXW'(BreathePer) - br_p;
  assign br_prod = BreatheProdW'(br_x) * BreatheMul;
  assign breathe = br_prod[BreatheShift +: ChanW];

  assign base_rgb = mask_r[ST_ARMED]    ? green_r  :
                    mask_r[ST_DISARMED] ? yellow_r :
                    mask_r[ST_BOOT]     ? blue_r   : '0;

  // Priority: flash, error, detection, offline, armed, disarmed, boot
  always_comb begin
    rgb   = '0;
    shown = SHOWN_OFF;
    if (flash_r != '0) begin
      rgb   = white_r;
      shown = SHOWN_DETECTION;
    end else if (mask_r[ST_ERROR]) begin
      rgb   = err_on ? red_r : '0;
      shown = SHOWN_ERROR;
    end else if (mask_r[ST_DETECTION]) begin
      rgb   = white_r;
      shown = SHOWN_DETECTION;
    end else if (mask_r[ST_OFFLINE]) begin
      rgb   = (phase_r < OfflineBlink) ? orange_r : base_rgb;
      shown = SHOWN_OFFLINE;
    end else if (mask_r[ST_ARMED]) begin
      rgb   = green_r;
      shown = SHOWN_ARMED;
    end else if (mask_r[ST_DISARMED]) begin
      rgb   = yellow_r;
      shown = SHOWN_DISARMED;
    end else if (mask_r[ST_BOOT]) begin
      rgb   = RgbW'(breathe);
      shown = SHOWN_BOOT;
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_take) begin
      out_valid_nxt = pend_r;
      if (pend_r) begin
        out_data_nxt = '0;
        out_data_nxt[OutRedLsb   +: ChanW]  = rgb[23:16];
        out_data_nxt[OutGreenLsb +: ChanW]  = rgb[15:8];
        out_data_nxt[OutBlueLsb  +: ChanW]  = rgb[7:0];
        out_data_nxt[OutShownLsb +: ShownW] = shown;
        out_data_nxt[OutMaskLsb  +: MaskW]  = mask_r;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      phase_r     <= '0;
      flash_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      red_r       <= RstRed;
      green_r     <= RstGreen;
      yellow_r    <= RstYellow;
      blue_r      <= RstBlue;
      orange_r    <= RstOrange;
      white_r     <= RstWhite;
    end else begin
      mask_r      <= mask_nxt;
      phase_r     <= phase_nxt;
      flash_r     <= flash_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      // Color register writes; indexes past the list are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RED:    red_r    <= cfg_data;
          REG_GREEN:  green_r  <= cfg_data;
          REG_YELLOW: yellow_r <= cfg_data;
          REG_BLUE:   blue_r   <= cfg_data;
          REG_ORANGE: orange_r <= cfg_data;
          REG_WHITE:  white_r  <= cfg_data;
          default:    red_r    <= red_r;
        endcase
      end
    end
  end

  // Payload register, no reset needed
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/core/slpg_checker.sv =====
`default_nettype none

module slpg_checker
  import slpg_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_tvalid,
  input wire logic                out_tready,
  input wire logic [OutDataW-1:0] out_tdata
);

  logic [ShownW-1:0] shown;
  assign shown = out_tdata[OutShownLsb +: ShownW];

  // No result beat right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // Nothing shown means a black LED
  a_off_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && shown == SHOWN_OFF |-> out_tdata[RgbW-1:0] == '0)
    else $error("off status with nonzero color");

  // Error can only win while its mask bit is set
  a_error_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && shown == SHOWN_ERROR |-> out_tdata[OutMaskLsb + ST_ERROR])
    else $error("error shown without error bit");

  // Boot breathing drives the blue channel only
  a_boot_blue: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && shown == SHOWN_BOOT |-> out_tdata[OutBlueLsb-1:0] == '0)
    else $error("boot pattern with red or green");

endmodule

bind status_led_pattern_generator slpg_checker u_slpg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import slpg_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 80;
  localparam int TAIL_CYCLES = 8;
  localparam int RAMP_TOP    = 255;

  // Status indexes and register indexes past the defined ones
  localparam logic [IdxW-1:0]    ST_SPARE6  = 3'd6;
  localparam logic [IdxW-1:0]    ST_SPARE7  = 3'd7;
  localparam logic [CfgIdxW-1:0] REG_SPARE6 = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_SPARE7 = 3'd7;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    shown_t           shown;
    logic [MaskW-1:0] mask;
  } led_view_t;

  typedef struct {
    kind_t           kind;
    logic [IdxW-1:0] idx;
    bit              typed;
    led_view_t       view;
  } led_probe_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata = '0;
  logic [InUserW-1:0]  in_tuser = KIND_TICK;
  logic                out_tvalid;
  logic                out_tready = 1'b1;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [RgbW-1:0]     cfg_data = '0;

  // Shadow of the engine state
  logic [MaskW-1:0]  status_bits = '0;
  logic [PhaseW-1:0] phase_now = '0;
  logic [7:0]        flash_left = '0;
  logic [RgbW-1:0]   led_colors [6];

  led_view_t expected_views [$];
  bit        probe_typed = 1'b0;
  led_view_t probe_view = '0;
  int        mismatches = 0;
  int        cycle_count = 0;
  int        gap_pct = 0;
  int        stall_pct = 0;
  bit        long_hold_req = 1'b0;

  // Directed beats; rows with a typed view are checked against it directly
  led_probe_t probes [21] = '{
    '{KIND_TICK,  ST_BOOT,      1'b1, '{8'h00, 8'h00, 8'h00, SHOWN_OFF,       6'h00}},
    '{KIND_SET,   ST_SPARE6,    1'b1, '{8'h00, 8'h00, 8'h00, SHOWN_OFF,       6'h00}},
    '{KIND_CLEAR, ST_SPARE7,    1'b1, '{8'h00, 8'h00, 8'h00, SHOWN_OFF,       6'h00}},
    '{KIND_SET,   ST_BOOT,      1'b1, '{8'h00, 8'h00, 8'h00, SHOWN_BOOT,      6'h01}},
    '{KIND_TICK,  ST_ERROR,     1'b0, '0},
    '{KIND_SET,   ST_DISARMED,  1'b1, '{8'hFF, 8'hFF, 8'h00, SHOWN_DISARMED,  6'h03}},
    '{KIND_SET,   ST_ARMED,     1'b1, '{8'h00, 8'hFF, 8'h00, SHOWN_ARMED,     6'h07}},
    '{KIND_SET,   ST_OFFLINE,   1'b1, '{8'hFF, 8'h80, 8'h00, SHOWN_OFFLINE,   6'h0F}},
    '{KIND_SET,   ST_DETECTION, 1'b1, '{8'hFF, 8'hFF, 8'hFF, SHOWN_DETECTION, 6'h1F}},
    '{KIND_SET,   ST_ERROR,     1'b1, '{8'hFF, 8'h00, 8'h00, SHOWN_ERROR,     6'h3F}},
    '{KIND_FLASH, ST_SPARE7,    1'b1, '{8'hFF, 8'hFF, 8'hFF, SHOWN_DETECTION, 6'h3F}},
    '{KIND_TICK,  ST_SPARE6,    1'b0, '0},
    '{KIND_FLASH, ST_BOOT,      1'b0, '0},
    '{KIND_CLEAR, ST_ERROR,     1'b0, '0},
    '{KIND_CLEAR, ST_DETECTION, 1'b0, '0},
    '{KIND_CLEAR, ST_OFFLINE,   1'b0, '0},
    '{KIND_CLEAR, ST_ARMED,     1'b0, '0},
    '{KIND_CLEAR, ST_DISARMED,  1'b0, '0},
    '{KIND_CLEAR, ST_BOOT,      1'b0, '0},
    '{KIND_SET,   ST_OFFLINE,   1'b0, '0},
    '{KIND_SET,   ST_SPARE7,    1'b0, '0}
  };

  status_led_pattern_generator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  initial begin
    led_colors[REG_RED]    = RstRed;
    led_colors[REG_GREEN]  = RstGreen;
    led_colors[REG_YELLOW] = RstYellow;
    led_colors[REG_BLUE]   = RstBlue;
    led_colors[REG_ORANGE] = RstOrange;
    led_colors[REG_WHITE]  = RstWhite;
  end

  // Apply one beat to the shadow state and work out the color it shows
  function automatic led_view_t step_led(input kind_t k, input logic [IdxW-1:0] idx);
    led_view_t       v;
    logic [RgbW-1:0] rgb;
    int              p;
    int              ramp;
    rgb = '0;
    v.shown = SHOWN_OFF;
    case (k)
      KIND_TICK: begin
        phase_now = (phase_now == PhaseLast) ? '0 : phase_now + PhaseW'(1);
        if (flash_left != 0) flash_left = flash_left - 8'(1);
      end
      KIND_SET: begin
        if (idx <= ST_ERROR) status_bits[idx] = 1'b1;
      end
      KIND_CLEAR: begin
        if (idx <= ST_ERROR) status_bits[idx] = 1'b0;
      end
      default: begin
        flash_left = 8'(FLASH_LENGTH_DEF);
      end
    endcase

    // Fixed priority: flash, error, detection, offline, armed, disarmed, boot
    if (flash_left != 0) begin
      v.shown = SHOWN_DETECTION;
      rgb = led_colors[REG_WHITE];
    end else if (status_bits[ST_ERROR]) begin
      v.shown = SHOWN_ERROR;
      rgb = (phase_now % BreatheHalf < ErrOn0End) ? led_colors[REG_RED] : '0;
    end else if (status_bits[ST_DETECTION]) begin
      v.shown = SHOWN_DETECTION;
      rgb = led_colors[REG_WHITE];
    end else if (status_bits[ST_OFFLINE]) begin
      v.shown = SHOWN_OFFLINE;
      if (phase_now < OfflineBlink) rgb = led_colors[REG_ORANGE];
      else if (status_bits[ST_ARMED]) rgb = led_colors[REG_GREEN];
      else if (status_bits[ST_DISARMED]) rgb = led_colors[REG_YELLOW];
      else if (status_bits[ST_BOOT]) rgb = led_colors[REG_BLUE];
    end else if (status_bits[ST_ARMED]) begin
      v.shown = SHOWN_ARMED;
      rgb = led_colors[REG_GREEN];
    end else if (status_bits[ST_DISARMED]) begin
      v.shown = SHOWN_DISARMED;
      rgb = led_colors[REG_YELLOW];
    end else if (status_bits[ST_BOOT]) begin
      // triangle breathe on the blue channel only
      v.shown = SHOWN_BOOT;
      p = int'(phase_now % BreathePer);
      if (p < int'(BreatheHalf)) ramp = p * RAMP_TOP / int'(BreatheHalf);
      else ramp = (int'(BreathePer) - p) * RAMP_TOP / int'(BreatheHalf);
      rgb = RgbW'(ramp);
    end

    v.red = rgb[23:16];
    v.green = rgb[15:8];
    v.blue = rgb[7:0];
    v.mask = status_bits;
    return v;
  endfunction

  task automatic flag_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Predict on every accepted input beat, check every accepted output beat
  always @(posedge clk) begin
    led_view_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, expected_views.size());
      $display("status_led_pattern_generator verification failed");
      $finish;
    end
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        want = step_led(kind_t'(in_tuser), in_tdata[IdxW-1:0]);
        if (probe_typed) want = probe_view;
        expected_views.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        if (expected_views.size() == 0) begin
          $display("%0t: result beat with none expected, expected nothing actual %0h",
                   $time, out_tdata);
          mismatches++;
        end else begin
          want = expected_views.pop_front();
          flag_field("red", int'(want.red), int'(out_tdata[OutRedLsb +: ChanW]));
          flag_field("green", int'(want.green), int'(out_tdata[OutGreenLsb +: ChanW]));
          flag_field("blue", int'(want.blue), int'(out_tdata[OutBlueLsb +: ChanW]));
          flag_field("shown_status", int'(want.shown),
                     int'(out_tdata[OutShownLsb +: ShownW]));
          flag_field("active_mask", int'(want.mask),
                     int'(out_tdata[OutMaskLsb +: MaskW]));
        end
      end
    end
  end

  // Result side back-pressure: random stalls plus one long hold on request
  initial begin
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_tready <= 1'b1;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  // Offer one beat, optionally after an idle burst; valid stays up on return
  task automatic send_beat(input kind_t k, input logic [IdxW-1:0] idx, input bit typed,
                           input led_view_t view);
    int gap;
    probe_typed = typed;
    probe_view = view;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 13);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= k;
    in_tdata <= InDataW'(idx);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_beats(input int count, input int tick_pct, input int flash_permil);
    kind_t           k;
    logic [IdxW-1:0] idx;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) == 0) idx = IdxW'($urandom_range(ST_SPARE6, ST_SPARE7));
      else idx = IdxW'($urandom_range(ST_BOOT, ST_ERROR));
      if ($urandom_range(0, 999) < flash_permil) k = KIND_FLASH;
      else if ($urandom_range(0, 99) < tick_pct) k = KIND_TICK;
      else if ($urandom_range(0, 4) < 2) k = KIND_SET;
      else k = KIND_CLEAR;
      send_beat(k, idx, 1'b0, '0);
    end
  endtask

  // Stop offering and wait until every expected beat has come out
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_views.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  // Write all six colors plus the two unused indexes; only while drained
  task automatic program_colors(input logic [RgbW-1:0] red_c, green_c, yellow_c,
                                input logic [RgbW-1:0] blue_c, orange_c, white_c);
    logic [RgbW-1:0]    words [8];
    logic [CfgIdxW-1:0] ri;
    words[REG_RED]    = red_c;
    words[REG_GREEN]  = green_c;
    words[REG_YELLOW] = yellow_c;
    words[REG_BLUE]   = blue_c;
    words[REG_ORANGE] = orange_c;
    words[REG_WHITE]  = white_c;
    words[REG_SPARE6] = RgbW'($urandom);
    words[REG_SPARE7] = RgbW'($urandom);
    for (int i = 0; i < 8; i++) begin
      ri = CfgIdxW'(i);
      cfg_valid <= 1'b1;
      cfg_index <= ri;
      cfg_data <= words[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      if (ri <= REG_WHITE) led_colors[ri] = words[i];
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed beats with reset colors
    gap_pct = 20;
    stall_pct = 20;
    for (int n = 0; n < $size(probes); n++)
      send_beat(probes[n].kind, probes[n].idx, probes[n].typed, probes[n].view);
    drain_results();

    // Extreme colors, then random traffic with a full drain in the middle
    program_colors(24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF);
    gap_pct = 10;
    stall_pct = 10;
    random_beats(200, 72, 5);
    drain_results();
    gap_pct = 0;
    stall_pct = 0;
    random_beats(200, 72, 5);
    drain_results();

    // Random colors; long tick run that carries the phase past the breathe peak
    program_colors(RgbW'($urandom), RgbW'($urandom), RgbW'($urandom),
                   RgbW'($urandom), RgbW'($urandom), RgbW'($urandom));
    gap_pct = 5;
    stall_pct = 5;
    random_beats(1000, 97, 1);
    drain_results();

    // Opposite extremes; long result hold while beats keep coming
    program_colors(24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000);
    gap_pct = 0;
    stall_pct = 0;
    long_hold_req = 1'b1;
    random_beats(100, 72, 5);
    gap_pct = 30;
    stall_pct = 30;
    random_beats(200, 72, 5);

    // Closing stretch at full rate
    gap_pct = 0;
    stall_pct = 0;
    random_beats(100, 72, 5);
    drain_results();

    if (mismatches == 0) begin
      $display("status_led_pattern_generator verification clean");
    end else begin
      $display("status_led_pattern_generator verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/slpg_pkg.sv
rtl/core/status_led_pattern_generator.sv
rtl/core/slpg_checker.sv
bench/tb_top.sv
